>>> rtl/core/assert_macros.svh
// Assertion macros shared by the checker files.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

>>> rtl/core/iate_pkg.sv
// Package for the indexed array table engine: command and status codes, mean width and divider request type.
// No dependencies.
`default_nettype none
package iate_pkg;
  localparam logic [2:0] CMD_FILL    = 3'd0;
  localparam logic [2:0] CMD_INSERT  = 3'd1;
  localparam logic [2:0] CMD_DELETE  = 3'd2;
  localparam logic [2:0] CMD_SEARCH  = 3'd3;
  localparam logic [2:0] CMD_REVERSE = 3'd4;
  localparam logic [2:0] CMD_DUMPF   = 3'd5;
  localparam logic [2:0] CMD_DUMPB   = 3'd6;
  localparam logic [2:0] CMD_STATS   = 3'd7;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BADIDX   = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_EMPTY    = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  localparam int MEAN_W = 40;

  typedef struct packed {
    logic               start;
    logic signed [47:0] dividend;
  } div_req_t;
endpackage
`default_nettype wire

>>> rtl/core/indexed_array_table_engine.sv
// Indexed array table engine: ordered table of signed entries with commands.
// Depends on iate_pkg and iate_div.
// Usage:
//   Input item (in_cmd, in_position, in_value) is taken when in_valid is high
//   and in_stall low. Results leave on out_* under out_valid/out_stall; the
//   final result of a command carries out_last.
//   The table sits in a synchronous memory with one write and one read port
//   and registered reads. Each command walks the memory one access per cycle
//   while the output is not stalled: fill writes each entry; insert and
//   delete move each shifted entry by a read and a write, and insert then
//   writes the new value; search reads each entry examined; dump reads each
//   entry; reverse reads and writes both entries of each swapped pair; stats
//   reads each entry and then runs the divider for the mean.
//   One command is in work at a time; in_stall is high from acceptance until
//   its last result is taken. A result waits in the output register while
//   out_stall is high; the walk pauses until it is taken.
//   Reset clears the count and the control; memory contents are not cleared
//   and are only read after they are written.
`default_nettype none
module indexed_array_table_engine
  import iate_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [2:0]               in_cmd,
  input  wire logic [6:0]               in_position,
  input  wire logic signed [31:0]       in_value,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [2:0]                    out_status,
  output logic [5:0]                    out_found_index,
  output logic signed [31:0]            out_entry,
  output logic signed [31:0]            out_minimum,
  output logic signed [31:0]            out_maximum,
  output logic [6:0]                    out_entry_count,
  output logic signed [MEAN_W-1:0]      out_mean,
  output logic                          out_last
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_USE  = 3'd2;
  localparam logic [2:0] S_RD2  = 3'd3;
  localparam logic [2:0] S_USE2 = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rdata_r;
  logic               we;
  logic [AW-1:0]      waddr, raddr;
  logic signed [31:0] wdata;

  logic [2:0]         st_r, st_nxt;
  logic [2:0]         cmd_r, cmd_nxt;
  logic [CW-1:0]      pos_r, pos_nxt, cnt_r, cnt_nxt, i_r, i_nxt, j_r, j_nxt;
  logic signed [31:0] val_r, val_nxt, tmp_r, tmp_nxt, mn_r, mn_nxt, mx_r, mx_nxt;
  logic signed [47:0] sum_r, sum_nxt;

  logic               ov_r, ov_nxt, ol_r, ol_nxt;
  logic [2:0]         os_r, os_nxt;
  logic [5:0]         oi_r, oi_nxt;
  logic signed [31:0] oe_r, oe_nxt, omn_r, omn_nxt, omx_r, omx_nxt;
  logic signed [MEAN_W-1:0] om_r, om_nxt;
  logic [6:0]         oc_r, oc_nxt;

  div_req_t                 dreq;
  logic                     ddone;
  logic signed [MEAN_W-1:0] dq;

  iate_div #(.CW(CW)) u_div (
    .clk(clk), .rst_n(rst_n), .req(dreq), .divisor(cnt_r),
    .done(ddone), .quotient(dq)
  );

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  always_comb begin
    st_nxt = st_r; cmd_nxt = cmd_r; pos_nxt = pos_r; cnt_nxt = cnt_r;
    i_nxt = i_r; j_nxt = j_r; val_nxt = val_r; tmp_nxt = tmp_r;
    mn_nxt = mn_r; mx_nxt = mx_r; sum_nxt = sum_r;
    ov_nxt = ov_r; ol_nxt = ol_r; os_nxt = os_r; oi_nxt = oi_r; oe_nxt = oe_r;
    omn_nxt = omn_r; omx_nxt = omx_r; om_nxt = om_r; oc_nxt = oc_r;
    we = 1'b0; waddr = '0; wdata = '0; raddr = '0;
    dreq.start = 1'b0; dreq.dividend = sum_r;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    case (st_r)
      S_IDLE: begin
        if (in_valid && !ov_r) begin
          cmd_nxt = in_cmd;
          pos_nxt = (in_position > 7'(DEPTH)) ? CW'(DEPTH) + CW'(1) : CW'(in_position);
          val_nxt = in_value;
          os_nxt = ST_OK; oi_nxt = '0; oe_nxt = '0; omn_nxt = '0; omx_nxt = '0;
          om_nxt = '0; ol_nxt = 1'b1;
          st_nxt = S_OUT;
          case (in_cmd)
            CMD_FILL: begin
              if (in_position == 7'd0 || in_position > 7'(DEPTH)) os_nxt = ST_BADIDX;
              else begin
                i_nxt = '0; st_nxt = S_RD;
              end
            end
            CMD_INSERT: begin
              if (in_position > 7'(cnt_r)) os_nxt = ST_BADIDX;
              else if (cnt_r == CW'(DEPTH)) os_nxt = ST_FULL;
              else begin
                i_nxt = cnt_r; st_nxt = S_RD;
              end
            end
            CMD_DELETE: begin
              if (cnt_r == '0) os_nxt = ST_EMPTY;
              else if (in_position >= 7'(cnt_r)) os_nxt = ST_BADIDX;
              else begin
                i_nxt = CW'(in_position); st_nxt = S_RD;
              end
            end
            CMD_SEARCH: begin
              if (cnt_r == '0) os_nxt = ST_NOTFOUND;
              else begin
                i_nxt = '0; st_nxt = S_RD;
              end
            end
            CMD_REVERSE: begin
              if (cnt_r > CW'(1)) begin
                i_nxt = '0; j_nxt = cnt_r - CW'(1); st_nxt = S_RD;
              end
            end
            CMD_DUMPF, CMD_DUMPB: begin
              if (cnt_r == '0) os_nxt = ST_EMPTY;
              else begin
                i_nxt = '0; st_nxt = S_RD;
              end
            end
            default: begin
              if (cnt_r == '0) os_nxt = ST_EMPTY;
              else begin
                i_nxt = '0; sum_nxt = '0; st_nxt = S_RD;
              end
            end
          endcase
        end
      end
      S_RD: begin
        case (cmd_r)
          CMD_FILL: begin
            we = 1'b1; waddr = i_r[AW-1:0]; wdata = 32'(i_r) + 32'sd1;
            i_nxt = i_r + CW'(1);
            if (i_nxt == pos_r) begin
              cnt_nxt = pos_r; oc_nxt = 7'(pos_r); st_nxt = S_OUT;
            end
          end
          CMD_INSERT: begin
            if (i_r == pos_r) begin
              we = 1'b1; waddr = i_r[AW-1:0]; wdata = val_r;
              cnt_nxt = cnt_r + CW'(1); oc_nxt = 7'(cnt_r + CW'(1)); st_nxt = S_OUT;
            end else begin
              raddr = AW'(i_r - CW'(1)); st_nxt = S_USE;
            end
          end
          CMD_DELETE: begin
            if (i_r + CW'(1) >= cnt_r) begin
              cnt_nxt = cnt_r - CW'(1); oc_nxt = 7'(cnt_r - CW'(1)); st_nxt = S_OUT;
            end else begin
              raddr = AW'(i_r + CW'(1)); st_nxt = S_USE;
            end
          end
          CMD_DUMPB: begin
            raddr = AW'(cnt_r - CW'(1) - i_r); st_nxt = S_USE;
          end
          CMD_REVERSE: begin
            raddr = i_r[AW-1:0]; st_nxt = S_USE;
          end
          default: begin
            raddr = i_r[AW-1:0]; st_nxt = S_USE;
          end
        endcase
      end
      S_USE: begin
        st_nxt = S_RD;
        case (cmd_r)
          CMD_INSERT: begin
            we = 1'b1; waddr = i_r[AW-1:0]; wdata = rdata_r; i_nxt = i_r - CW'(1);
          end
          CMD_DELETE: begin
            we = 1'b1; waddr = i_r[AW-1:0]; wdata = rdata_r; i_nxt = i_r + CW'(1);
          end
          CMD_SEARCH: begin
            i_nxt = i_r + CW'(1);
            if (rdata_r == val_r) begin
              oi_nxt = 6'(i_r); oc_nxt = 7'(cnt_r); st_nxt = S_OUT;
            end else if (i_nxt == cnt_r) begin
              os_nxt = ST_NOTFOUND; oc_nxt = 7'(cnt_r); st_nxt = S_OUT;
            end
          end
          CMD_REVERSE: begin
            tmp_nxt = rdata_r; raddr = j_r[AW-1:0]; st_nxt = S_RD2;
          end
          CMD_DUMPF, CMD_DUMPB: begin
            // keep the read address so the entry holds while the output waits
            raddr = (cmd_r == CMD_DUMPF) ? i_r[AW-1:0] : AW'(cnt_r - CW'(1) - i_r);
            if (!ov_r || !out_stall) begin
              ov_nxt = 1'b1; os_nxt = ST_OK;
              oi_nxt = (cmd_r == CMD_DUMPF) ? 6'(i_r) : 6'(cnt_r - CW'(1) - i_r);
              oe_nxt = rdata_r; oc_nxt = 7'(cnt_r);
              omn_nxt = '0; omx_nxt = '0; om_nxt = '0;
              ol_nxt = (i_r + CW'(1) == cnt_r);
              i_nxt = i_r + CW'(1);
              st_nxt = (i_r + CW'(1) == cnt_r) ? S_IDLE : S_RD;
            end else st_nxt = S_USE;
          end
          default: begin
            if (i_r == '0 || rdata_r < mn_r) mn_nxt = rdata_r;
            if (i_r == '0 || rdata_r > mx_r) mx_nxt = rdata_r;
            sum_nxt = sum_r + 48'(rdata_r);
            i_nxt = i_r + CW'(1);
            if (i_nxt == cnt_r) begin
              dreq.start = 1'b1;
              dreq.dividend = (sum_r + 48'(rdata_r)) <<< 8;
              st_nxt = S_DIV;
            end
          end
        endcase
      end
      S_RD2: begin
        // high entry is in rdata_r: store it at the low index
        we = 1'b1; waddr = i_r[AW-1:0]; wdata = rdata_r; st_nxt = S_USE2;
      end
      S_USE2: begin
        we = 1'b1; waddr = j_r[AW-1:0]; wdata = tmp_r;
        i_nxt = i_r + CW'(1); j_nxt = j_r - CW'(1);
        st_nxt = (i_r + CW'(1) >= j_r - CW'(1)) ? S_OUT : S_RD;
      end
      S_DIV: begin
        if (ddone) begin
          omn_nxt = mn_r; omx_nxt = mx_r; om_nxt = dq; oc_nxt = 7'(cnt_r);
          st_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!ov_r) begin
          ov_nxt = 1'b1; ol_nxt = 1'b1; oc_nxt = 7'(cnt_r); st_nxt = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; cnt_r <= '0; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; cnt_r <= cnt_nxt; ov_r <= ov_nxt;
    end
    cmd_r <= cmd_nxt; pos_r <= pos_nxt; i_r <= i_nxt; j_r <= j_nxt;
    val_r <= val_nxt; tmp_r <= tmp_nxt; mn_r <= mn_nxt; mx_r <= mx_nxt;
    sum_r <= sum_nxt; ol_r <= ol_nxt; os_r <= os_nxt; oi_r <= oi_nxt;
    oe_r <= oe_nxt; omn_r <= omn_nxt; omx_r <= omx_nxt; om_r <= om_nxt;
    oc_r <= oc_nxt;
  end

  assign in_stall = (st_r != S_IDLE) || ov_r;
  assign out_valid = ov_r;
  assign out_status = os_r;
  assign out_found_index = oi_r;
  assign out_entry = oe_r;
  assign out_minimum = omn_r;
  assign out_maximum = omx_r;
  assign out_entry_count = oc_r;
  assign out_mean = om_r;
  assign out_last = ol_r;
endmodule
`default_nettype wire

>>> rtl/core/iate_div.sv
// Restoring divider for the mean: signed dividend by unsigned count.
// Depends on iate_pkg. One quotient bit per cycle, truncates toward zero.
`default_nettype none
module iate_div
  import iate_pkg::*;
#(
  parameter int CW = 7
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire div_req_t            req,
  input  wire logic [CW-1:0]       divisor,
  output logic                     done,
  output logic signed [MEAN_W-1:0] quotient
);
  localparam int NW = 48;
  localparam int SW = $clog2(NW + 1);

  logic [NW-1:0] q_r, q_nxt;
  logic [CW-1:0] rem_r, rem_nxt;
  logic [SW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt, neg_r, neg_nxt, done_r, done_nxt;
  logic [CW:0]   trial;
  logic [NW-1:0] qneg;

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    neg_nxt = neg_r;
    done_nxt = 1'b0;
    trial = {rem_r, q_r[NW-1]};
    if (req.start) begin
      neg_nxt = req.dividend[NW-1];
      q_nxt = req.dividend[NW-1] ? NW'(-req.dividend) : NW'(req.dividend);
      rem_nxt = '0;
      cnt_nxt = SW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = CW'(trial - {1'b0, divisor});
        q_nxt = {q_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = CW'(trial);
        q_nxt = {q_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - SW'(1);
      if (cnt_r == SW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    neg_r <= neg_nxt;
  end

  assign qneg = -q_r;
  assign done = done_r;
  assign quotient = neg_r ? MEAN_W'(qneg) : MEAN_W'(q_r);
endmodule
`default_nettype wire

>>> rtl/core/iate_checker.sv
// Port-level checker for the indexed array table engine, bound to the top.
// Depends on assert_macros.svh and iate_pkg.
`default_nettype none
`include "assert_macros.svh"
module iate_checker
  import iate_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [2:0] out_status,
  input wire logic [6:0] out_entry_count,
  input wire logic       out_last
);
  `CHK_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_status))
  `CHK_NEXT(a_take, clk, rst_n, in_valid && !in_stall, in_stall)
  `CHK_IMPL(a_stat, clk, rst_n, out_valid, out_status <= ST_NOTFOUND)
  `CHK_IMPL(a_cnt, clk, rst_n, out_valid, out_entry_count <= 7'd64)
  `CHK_IMPL(a_err, clk, rst_n, out_valid && out_status != ST_OK, out_last)
endmodule

bind indexed_array_table_engine iate_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
  .out_entry_count(out_entry_count), .out_last(out_last)
);
`default_nettype wire
